// ===== hw/rtl/ltp_pkg.sv =====
// Shared constants and types for the local-extrema trade profit block.
package ltp_pkg;

	// Fixed field widths of the result record and the configuration data.
	localparam int ROUND_BITS = 32;
	localparam int TRADE_BITS = 32;
	localparam int AVG_BITS   = 24;
	localparam int AVG_FRAC   = 8;
	localparam int ITEMS_BITS = 16;

	// Dividend and divisor widths of the average-trades division.
	localparam int DIVIDEND_BITS = TRADE_BITS + AVG_FRAC;
	localparam int DIVISOR_BITS  = ROUND_BITS + 1;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ITEMS_PER_ROUND = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_ITEMS      = 2'd1;

	// Reset value and lower bound of the items-per-round register.
	localparam logic [ITEMS_BITS-1:0] ITEMS_RESET = 16'd16;
	localparam logic [ITEMS_BITS-1:0] ITEMS_MIN   = 16'd2;

	// Depth of the record queue between front and back, as log2.
	localparam int QUEUE_DEPTH_LOG2 = 2;

	// Fixed-width part of a per-round record.
	typedef struct packed {
		logic [ROUND_BITS-1:0] round_index;
		logic [TRADE_BITS-1:0] total_trades;
		logic                  final_round;
	} rec_ctl_t;

endpackage

// ===== hw/rtl/local_extrema_trade_profit.sv =====
// Top level of the local-extrema trade profit block.
//
//   Channel   Handshake                 Payload
//   input     push / full               price, last_of_series
//   result    empty / pop               round_index, total_gain, total_trades,
//                                       avg_trades, final_round
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The front end takes one price sample per cycle while full is low; gain and trades update
// in that cycle. Each completed round yields one record in a four-entry queue; the back
// end's bit-serial divider takes one record at a time. Rounds shorter than the divider's
// time per record therefore fill the queue, and full then holds off input. Reset clears
// control state at once, not storage; no clearing pass is needed. cfg_ready is always high.
module local_extrema_trade_profit #(
	parameter int PRICE_BITS = 16,
	parameter int GAIN_BITS  = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [PRICE_BITS-1:0]            price,
	input  logic                             last_of_series,
	output logic                             empty,
	input  logic                             pop,
	output logic [ltp_pkg::ROUND_BITS-1:0]   round_index,
	output logic [GAIN_BITS-1:0]             total_gain,
	output logic [ltp_pkg::TRADE_BITS-1:0]   total_trades,
	output logic [ltp_pkg::AVG_BITS-1:0]     avg_trades,
	output logic                             final_round,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ltp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [ltp_pkg::ITEMS_BITS-1:0]   cfg_data
);

	localparam int QW = $bits(ltp_pkg::rec_ctl_t) + GAIN_BITS;

	logic                 rec_push;
	ltp_pkg::rec_ctl_t    rec_ctl;
	logic [GAIN_BITS-1:0] rec_gain;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	logic [QW-1:0]        q_rdata;
	ltp_pkg::rec_ctl_t    q_ctl;
	logic [GAIN_BITS-1:0] q_gain;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// Sample classification and accumulation.
	ltp_front #(
		.PRICE_BITS (PRICE_BITS),
		.GAIN_BITS  (GAIN_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.stall          (q_full),
		.price          (price),
		.last_of_series (last_of_series),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rec_push       (rec_push),
		.rec_ctl        (rec_ctl),
		.rec_gain       (rec_gain)
	);

	// Per-round record queue.
	ltp_queue #(
		.WIDTH      (QW),
		.DEPTH_LOG2 (ltp_pkg::QUEUE_DEPTH_LOG2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.full   (q_full),
		.wdata  ({rec_ctl, rec_gain}),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign q_ctl  = q_rdata[QW-1:GAIN_BITS];
	assign q_gain = q_rdata[GAIN_BITS-1:0];

	// Average computation and result register.
	ltp_back #(
		.GAIN_BITS (GAIN_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_ctl        (q_ctl),
		.q_gain       (q_gain),
		.empty        (empty),
		.pop          (pop),
		.round_index  (round_index),
		.total_gain   (total_gain),
		.total_trades (total_trades),
		.avg_trades   (avg_trades),
		.final_round  (final_round)
	);

endmodule

// ===== hw/rtl/ltp_front.sv =====
// Front end: tracks local extrema, accumulates gain and trades, issues per-round records.
module ltp_front #(
	parameter int PRICE_BITS = 16,
	parameter int GAIN_BITS  = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic                               stall,
	input  logic [PRICE_BITS-1:0]              price,
	input  logic                               last_of_series,
	input  logic                               cfg_valid,
	input  logic [ltp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ltp_pkg::ITEMS_BITS-1:0]     cfg_data,
	output logic                               rec_push,
	output ltp_pkg::rec_ctl_t                  rec_ctl,
	output logic [GAIN_BITS-1:0]               rec_gain
);

	// Sum width: holds gain plus two price-sized terms without overflow.
	localparam int SW = ((GAIN_BITS > PRICE_BITS) ? GAIN_BITS : PRICE_BITS + 1) + 2;
	localparam logic signed [SW-1:0] GAIN_MAX =
		{{(SW-GAIN_BITS+1){1'b0}}, {(GAIN_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] GAIN_MIN =
		{{(SW-GAIN_BITS+1){1'b1}}, {(GAIN_BITS-1){1'b0}}};

	logic [ltp_pkg::ITEMS_BITS-1:0] items_q;
	logic                           keep_q;

	logic [PRICE_BITS-1:0]          held_price_q;
	logic                           held_rose_q;
	logic                           held_valid_q;
	logic                           held_at_edge_q;
	logic [ltp_pkg::ITEMS_BITS-1:0] pos_q;
	logic [ltp_pkg::ROUND_BITS-1:0] round_q;
	logic [GAIN_BITS-1:0]           gain_q;
	logic [ltp_pkg::TRADE_BITS-1:0] trades_q;

	logic                           accept;
	logic [ltp_pkg::ITEMS_BITS-1:0] n_eff;
	logic                           edge_close;
	logic                           right;
	logic                           left;
	logic                           wrap;
	logic                           add_p;
	logic                           trade_inc;
	logic                           emit;
	logic signed [SW-1:0]           h_ext;
	logic signed [SW-1:0]           p_ext;
	logic signed [SW-1:0]           g_ext;
	logic signed [SW-1:0]           d1;
	logic signed [SW-1:0]           d2;
	logic signed [SW-1:0]           t1;
	logic signed [SW-1:0]           base;
	logic signed [SW-1:0]           s;
	logic signed [SW-1:0]           s_sat;
	logic [GAIN_BITS-1:0]           gain_new;
	logic [ltp_pkg::TRADE_BITS-1:0] trades_new;

	assign accept = push && !stall;

	// Classify the incoming sample against the held one and form the gain update.
	always_comb begin
		n_eff      = (items_q < ltp_pkg::ITEMS_MIN) ? ltp_pkg::ITEMS_MIN : items_q;
		edge_close = held_valid_q && held_at_edge_q && !keep_q;
		right      = held_price_q <= price;
		h_ext      = {{(SW-PRICE_BITS){1'b0}}, held_price_q};
		p_ext      = {{(SW-PRICE_BITS){1'b0}}, price};
		g_ext      = {{(SW-GAIN_BITS){gain_q[GAIN_BITS-1]}}, gain_q};

		d1 = '0;
		if (held_valid_q && held_rose_q) begin
			d1 = h_ext;
		end
		if (held_valid_q && !edge_close && right) begin
			d1 = d1 - h_ext;
		end
		trade_inc = held_valid_q && !edge_close && held_rose_q && !right;

		left  = held_valid_q && (keep_q || !held_at_edge_q) && (price >= held_price_q);
		wrap  = pos_q >= (n_eff - 16'd1);
		add_p = left && (last_of_series || (wrap && !keep_q));
		d2    = add_p ? p_ext : '0;

		// Two saturating adds in order: the held term first, then this sample.
		t1   = g_ext + d1;
		base = (t1 < GAIN_MIN) ? GAIN_MIN : t1;
		s    = base + d2;
		if (s > GAIN_MAX) begin
			s_sat = GAIN_MAX;
		end else if (s < GAIN_MIN) begin
			s_sat = GAIN_MIN;
		end else begin
			s_sat = s;
		end
		gain_new = s_sat[GAIN_BITS-1:0];

		trades_new = (trade_inc && (trades_q != '1)) ? trades_q + 1'b1 : trades_q;

		emit = (held_valid_q && held_at_edge_q) || last_of_series || (wrap && !keep_q);
	end

	// Record sent to the back end for each completed round.
	assign rec_push             = accept && emit;
	assign rec_ctl.round_index  = round_q;
	assign rec_ctl.total_trades = trades_new;
	assign rec_ctl.final_round  = last_of_series;
	assign rec_gain             = gain_new;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= ltp_pkg::ITEMS_RESET;
			keep_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ltp_pkg::CFG_ITEMS_PER_ROUND: items_q <= cfg_data;
				ltp_pkg::CFG_KEEP_ITEMS:      keep_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sample window and accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_price_q   <= '0;
			held_rose_q    <= 1'b0;
			held_valid_q   <= 1'b0;
			held_at_edge_q <= 1'b0;
			pos_q          <= '0;
			round_q        <= '0;
			gain_q         <= '0;
			trades_q       <= '0;
		end else if (accept) begin
			if (last_of_series) begin
				held_price_q   <= '0;
				held_rose_q    <= 1'b0;
				held_valid_q   <= 1'b0;
				held_at_edge_q <= 1'b0;
				pos_q          <= '0;
				round_q        <= '0;
				gain_q         <= '0;
				trades_q       <= '0;
			end else begin
				gain_q   <= gain_new;
				trades_q <= trades_new;
				if (emit) begin
					round_q <= round_q + 1'b1;
				end
				if (wrap) begin
					pos_q <= '0;
					if (keep_q) begin
						held_price_q   <= price;
						held_rose_q    <= left;
						held_valid_q   <= 1'b1;
						held_at_edge_q <= 1'b1;
					end else begin
						held_price_q   <= '0;
						held_rose_q    <= 1'b0;
						held_valid_q   <= 1'b0;
						held_at_edge_q <= 1'b0;
					end
				end else begin
					held_price_q   <= price;
					held_rose_q    <= left;
					held_valid_q   <= 1'b1;
					held_at_edge_q <= 1'b0;
					pos_q          <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ltp_queue.sv =====
// Small register queue that decouples the front end from the back end.
module ltp_queue #(
	parameter int WIDTH      = 8,
	parameter int DEPTH_LOG2 = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]    entries_q [DEPTH];
	logic [DEPTH_LOG2:0] wr_ptr_q;
	logic [DEPTH_LOG2:0] rd_ptr_q;

	// Pointers carry one extra wrap bit to tell full from empty.
	assign empty = wr_ptr_q == rd_ptr_q;
	assign full  = (wr_ptr_q[DEPTH_LOG2] != rd_ptr_q[DEPTH_LOG2]) &&
		(wr_ptr_q[DEPTH_LOG2-1:0] == rd_ptr_q[DEPTH_LOG2-1:0]);
	assign rdata = entries_q[rd_ptr_q[DEPTH_LOG2-1:0]];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entries_q[wr_ptr_q[DEPTH_LOG2-1:0]] <= wdata;
		end
	end

	// Read and write pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ltp_back.sv =====
// Back end: divides trades by rounds one quotient bit a cycle and holds the result register.
module ltp_back #(
	parameter int GAIN_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  ltp_pkg::rec_ctl_t              q_ctl,
	input  logic [GAIN_BITS-1:0]           q_gain,
	output logic                           empty,
	input  logic                           pop,
	output logic [ltp_pkg::ROUND_BITS-1:0] round_index,
	output logic [GAIN_BITS-1:0]           total_gain,
	output logic [ltp_pkg::TRADE_BITS-1:0] total_trades,
	output logic [ltp_pkg::AVG_BITS-1:0]   avg_trades,
	output logic                           final_round
);

	localparam int QB = ltp_pkg::DIVIDEND_BITS;
	localparam int VB = ltp_pkg::DIVISOR_BITS;
	localparam int CB = $clog2(QB + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]              state_q;
	logic [CB-1:0]           cnt_q;
	logic [QB-1:0]           quot_q;
	logic [VB-2:0]           rem_q;
	logic [VB-1:0]           divisor_q;
	ltp_pkg::rec_ctl_t       ctl_q;
	logic [GAIN_BITS-1:0]    gain_q;

	logic                    out_valid_q;
	ltp_pkg::rec_ctl_t       out_ctl_q;
	logic [GAIN_BITS-1:0]    out_gain_q;
	logic [ltp_pkg::AVG_BITS-1:0] out_avg_q;

	logic [VB-1:0]           rem_sh;
	logic                    fits;
	logic [VB-1:0]           rem_diff;
	logic                    load_out;
	logic [ltp_pkg::AVG_BITS-1:0] avg_sat;

	// One restoring division step.
	always_comb begin
		rem_sh   = {rem_q, quot_q[QB-1]};
		fits     = rem_sh >= divisor_q;
		rem_diff = rem_sh - divisor_q;
	end

	// Quotient clamps to the average field's range.
	assign avg_sat = (|quot_q[QB-1:ltp_pkg::AVG_BITS]) ? '1 : quot_q[ltp_pkg::AVG_BITS-1:0];

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || pop);

	// Division sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_DIV;
						cnt_q   <= CB'(QB);
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CB'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Division datapath and captured record.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q     <= q_ctl;
			gain_q    <= q_gain;
			quot_q    <= {q_ctl.total_trades, {ltp_pkg::AVG_FRAC{1'b0}}};
			rem_q     <= '0;
			divisor_q <= {1'b0, q_ctl.round_index} + 1'b1;
		end else if (state_q == ST_DIV) begin
			quot_q <= {quot_q[QB-2:0], fits};
			rem_q  <= fits ? rem_diff[VB-2:0] : rem_sh[VB-2:0];
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ctl_q  <= ctl_q;
			out_gain_q <= gain_q;
			out_avg_q  <= avg_sat;
		end
	end

	assign empty        = !out_valid_q;
	assign round_index  = out_ctl_q.round_index;
	assign total_gain   = out_gain_q;
	assign total_trades = out_ctl_q.total_trades;
	assign avg_trades   = out_avg_q;
	assign final_round  = out_ctl_q.final_round;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the local-extrema trade profit block.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRICE_W = 16;
	localparam int GAIN_W  = 48;
	localparam longint GAIN_TOP    = (longint'(1) <<< (GAIN_W - 1)) - 1;
	localparam longint GAIN_BOTTOM = -GAIN_TOP - 1;
	// Cycles to let the divider finish after the last expected round report.
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;

	// One price sample on its way into the block.
	typedef struct {
		logic [PRICE_W-1:0] price;
		logic               last;
	} quote_t;

	// One per-round report as the block should give it.
	typedef struct {
		logic [ltp_pkg::ROUND_BITS-1:0] round_index;
		logic [GAIN_W-1:0]              gain;
		logic [ltp_pkg::TRADE_BITS-1:0] trades;
		logic [ltp_pkg::AVG_BITS-1:0]   avg;
		logic                           final_round;
	} round_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [PRICE_W-1:0] price = '0;
	logic last_of_series = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [ltp_pkg::CFG_IDX_BITS-1:0] cfg_index = ltp_pkg::CFG_ITEMS_PER_ROUND;
	logic [ltp_pkg::ITEMS_BITS-1:0] cfg_data = '0;
	logic full;
	logic empty;
	logic cfg_ready;
	logic [ltp_pkg::ROUND_BITS-1:0] round_index;
	logic [GAIN_W-1:0] total_gain;
	logic [ltp_pkg::TRADE_BITS-1:0] total_trades;
	logic [ltp_pkg::AVG_BITS-1:0] avg_trades;
	logic final_round;

	quote_t quotes_waiting[$];
	round_report_t reports_due[$];
	logic quote_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stalls_asked = 0;
	int stalls_served = 0;
	int hold_left = 0;
	int errors = 0;

	// Mirror of the block's registers and running state.
	logic [ltp_pkg::ITEMS_BITS-1:0] round_len = ltp_pkg::ITEMS_RESET;
	logic keep_window = 1'b0;
	logic [PRICE_W-1:0] hold_px;
	logic hold_up;
	logic hold_ok;
	logic hold_edge;
	logic [ltp_pkg::ITEMS_BITS-1:0] slot;
	logic [ltp_pkg::ROUND_BITS-1:0] round_no;
	longint gain_acc;
	logic [ltp_pkg::TRADE_BITS-1:0] trade_acc;

	local_extrema_trade_profit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.price(price),
		.last_of_series(last_of_series),
		.empty(empty),
		.pop(pop),
		.round_index(round_index),
		.total_gain(total_gain),
		.total_trades(total_trades),
		.avg_trades(avg_trades),
		.final_round(final_round),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat_gain(input longint acc, input longint delta);
		longint sum;
		sum = acc + delta;
		if (sum > GAIN_TOP)
			sum = GAIN_TOP;
		if (sum < GAIN_BOTTOM)
			sum = GAIN_BOTTOM;
		return sum;
	endfunction

	task automatic clear_series();
		hold_px = '0;
		hold_up = 1'b0;
		hold_ok = 1'b0;
		hold_edge = 1'b0;
		slot = '0;
		round_no = '0;
		gain_acc = 0;
		trade_acc = '0;
	endtask

	// Queue the report for the round that is closing now.
	task automatic post_report(input logic is_final);
		round_report_t r;
		longint unsigned avg;
		avg = (longint'(trade_acc) << ltp_pkg::AVG_FRAC) / (longint'(round_no) + 1);
		if (avg > 64'hFF_FFFF)
			avg = 64'hFF_FFFF;
		r.round_index = round_no;
		r.gain = gain_acc[GAIN_W-1:0];
		r.trades = trade_acc;
		r.avg = avg[ltp_pkg::AVG_BITS-1:0];
		r.final_round = is_final;
		reports_due.push_back(r);
	endtask

	// Settle the held sample against the new one and advance the round position.
	task automatic book_sample(input logic [PRICE_W-1:0] p, input logic last);
		int n;
		logic keep;
		logic left;
		logic right;
		longint h;
		n = (round_len < 2) ? 2 : int'(round_len);
		keep = keep_window;
		if (hold_ok) begin
			h = longint'(hold_px);
			if (hold_edge && !keep) begin
				if (hold_up)
					gain_acc = sat_gain(gain_acc, h);
			end else begin
				right = hold_px <= p;
				gain_acc = sat_gain(gain_acc, (hold_up ? h : 0) - (right ? h : 0));
				if (hold_up && !right && trade_acc != '1)
					trade_acc = trade_acc + 1;
			end
			if (hold_edge && !last) begin
				post_report(1'b0);
				round_no = round_no + 1;
			end
		end
		left = hold_ok && (keep || !hold_edge) && p >= hold_px;
		if (last) begin
			if (left)
				gain_acc = sat_gain(gain_acc, longint'(p));
			post_report(1'b1);
			clear_series();
		end else if (int'(slot) >= n - 1) begin
			slot = '0;
			if (keep) begin
				hold_px = p;
				hold_up = left;
				hold_ok = 1'b1;
				hold_edge = 1'b1;
			end else begin
				if (left)
					gain_acc = sat_gain(gain_acc, longint'(p));
				post_report(1'b0);
				round_no = round_no + 1;
				hold_px = '0;
				hold_up = 1'b0;
				hold_ok = 1'b0;
				hold_edge = 1'b0;
			end
		end else begin
			hold_px = p;
			hold_up = left;
			hold_ok = 1'b1;
			hold_edge = 1'b0;
			slot = slot + 1'b1;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, want, got);
			errors++;
		end
	endtask

	// Sender: offer the next waiting sample, or idle at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || quote_taken) begin
			if (quotes_waiting.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				push <= 1'b1;
				price <= quotes_waiting[0].price;
				last_of_series <= quotes_waiting[0].last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: pop at random, with an occasional long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stalls_served != stalls_asked) begin
			stalls_served <= stalls_asked;
			hold_left <= HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: predict on each accepted sample and check each popped report.
	always @(posedge clk) begin
		quote_t q;
		round_report_t want;
		quote_taken <= arst_n && push && !full;
		if (arst_n && push && !full) begin
			q = quotes_waiting.pop_front();
			book_sample(q.price, q.last);
		end
		if (arst_n && pop && !empty) begin
			if (reports_due.size() == 0) begin
				$display("%0t: report for round %0d arrived with none expected",
					$realtime, round_index);
				errors++;
			end else begin
				want = reports_due.pop_front();
				check_field("round_index", 64'(round_index), 64'(want.round_index));
				check_field("total_gain", 64'(total_gain), 64'(want.gain));
				check_field("total_trades", 64'(total_trades), 64'(want.trades));
				check_field("avg_trades", 64'(avg_trades), 64'(want.avg));
				check_field("final_round", 64'(final_round), 64'(want.final_round));
			end
		end
	end

	task automatic write_reg(input logic [ltp_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [ltp_pkg::ITEMS_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == ltp_pkg::CFG_ITEMS_PER_ROUND)
			round_len = val;
		else if (idx == ltp_pkg::CFG_KEEP_ITEMS)
			keep_window = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_quote(input int p, input logic last);
		quote_t q;
		q.price = p[PRICE_W-1:0];
		q.last = last;
		quotes_waiting.push_back(q);
	endtask

	// Wait until every sample is taken and every report popped, then let the divider settle.
	task automatic drain();
		while (quotes_waiting.size() != 0 || reports_due.size() != 0 || push)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One series of prices in one of several shapes; closed with the series-end mark or cut.
	task automatic add_series(input int len, input logic close);
		int shape;
		int cur;
		int p;
		shape = $urandom_range(0, 3);
		cur = $urandom_range(0, 65535);
		for (int i = 0; i < len; i++) begin
			case (shape)
				0: p = $urandom_range(0, 65535);
				1: begin
					// Small steps leave many plateaus and shallow extrema.
					cur = cur + $urandom_range(0, 4) - 2;
					if (cur < 0)
						cur = 0;
					if (cur > 65535)
						cur = 65535;
					p = cur;
				end
				2: p = $urandom_range(0, 3) * 21845;
				default: p = $urandom_range(0, 1) ? 65535 : 0;
			endcase
			add_quote(p, close && i == len - 1);
		end
	endtask

	task automatic run_phase(input int len, input logic keep, input int count);
		int added;
		int span;
		int n;
		write_reg(ltp_pkg::CFG_ITEMS_PER_ROUND, len[ltp_pkg::ITEMS_BITS-1:0]);
		write_reg(ltp_pkg::CFG_KEEP_ITEMS, {{(ltp_pkg::ITEMS_BITS-1){1'b0}}, keep});
		n = (len < 2) ? 2 : ((len > 40) ? 40 : len);
		added = 0;
		while (added < count) begin
			span = $urandom_range(1, 4 * n + 2);
			if (added + span >= count)
				span = count - added;
			// Now and then a series is left open so the next setting meets it mid-run.
			add_series(span, !(added + span >= count && $urandom_range(0, 4) == 0));
			added += span;
		end
		drain();
	endtask

	// Idle pattern by stage of the run: receiver sparse first, then sender, then neither.
	task automatic set_idle(input int snd, input int rcv);
		send_idle_pct = snd;
		recv_idle_pct = rcv;
	endtask

	initial begin
		clear_series();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: each round stands alone, rounds of four.
		set_idle(23, 56);
		write_reg(ltp_pkg::CFG_ITEMS_PER_ROUND, 16'd4);
		write_reg(ltp_pkg::CFG_KEEP_ITEMS, 16'd0);
		add_quote(16'h1234, 1'b1);
		add_quote(16'h0000, 1'b0);
		add_quote(16'hFFFF, 1'b0);
		add_quote(16'h0000, 1'b0);
		add_quote(16'hFFFF, 1'b0);
		add_quote(16'h8000, 1'b0);
		add_quote(16'h8000, 1'b0);
		add_quote(16'h7FFF, 1'b0);
		add_quote(16'h0001, 1'b0);
		add_quote(16'h0101, 1'b1);
		drain();

		// Directed: windows span rounds of three, ending on a round's first sample.
		write_reg(ltp_pkg::CFG_ITEMS_PER_ROUND, 16'd3);
		write_reg(ltp_pkg::CFG_KEEP_ITEMS, 16'd1);
		add_quote(16'h0005, 1'b0);
		add_quote(16'h0009, 1'b0);
		add_quote(16'h0009, 1'b0);
		add_quote(16'h0004, 1'b0);
		add_quote(16'h0004, 1'b0);
		add_quote(16'hFFFF, 1'b0);
		add_quote(16'h0000, 1'b0);
		add_quote(16'h00FF, 1'b0);
		add_quote(16'h00FE, 1'b0);
		add_quote(16'h2000, 1'b1);
		drain();

		// Random phases over many settings.
		run_phase(2, 1'b0, 120);
		run_phase(5, 1'b1, 120);
		run_phase(3, 1'b0, 110);
		run_phase(16, 1'b1, 120);

		set_idle(56, 23);
		stalls_asked++;
		run_phase(0, 1'b1, 110);
		run_phase(8, 1'b0, 120);
		run_phase(1, 1'b0, 110);
		run_phase(12, 1'b1, 120);

		set_idle(0, 0);
		run_phase(65535, 1'b1, 60);
		run_phase(65535, 1'b0, 40);
		stalls_asked++;
		run_phase(2, 1'b1, 120);
		run_phase(7, 1'b0, 120);
		run_phase(40, 1'b1, 100);
		run_phase($urandom_range(2, 20), 1'($urandom_range(0, 1)), 120);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== local_extrema_trade_profit.f =====
hw/rtl/ltp_pkg.sv
hw/rtl/ltp_front.sv
hw/rtl/ltp_queue.sv
hw/rtl/ltp_back.sv
hw/rtl/local_extrema_trade_profit.sv
tb/tb_top.sv
